/* design/tmpm_pkg.sv */
// Package for the touch-to-mouse pinch mapper.
// Action codes, button codes, register indexes, wheel limits and the sequencer state type.
// No dependencies.
package tmpm_pkg;

  // Pointer ids at or above this value are dropped.
  localparam int MAX_POINTERS = 10;
  localparam int PID_W        = 4;

  // Low byte of the motion action code.
  localparam logic [7:0] ACT_DOWN     = 8'd0;
  localparam logic [7:0] ACT_UP       = 8'd1;
  localparam logic [7:0] ACT_MOVE     = 8'd2;
  localparam logic [7:0] ACT_CANCEL   = 8'd3;
  localparam logic [7:0] ACT_PTR_DOWN = 8'd5;
  localparam logic [7:0] ACT_PTR_UP   = 8'd6;

  // Left button report codes.
  localparam logic [1:0] LEFT_NONE = 2'd0;
  localparam logic [1:0] LEFT_DOWN = 2'd1;
  localparam logic [1:0] LEFT_UP   = 2'd2;

  // Configuration register indexes.
  localparam int         CFG_IDX_W     = 1;
  localparam int         CFG_DATA_W    = 16;
  localparam logic [0:0] REG_THRESHOLD = 1'b0;
  localparam logic [0:0] REG_GAIN      = 1'b1;

  localparam int THR_W  = 16;
  localparam int GAIN_W = 4;

  // Wheel output and its saturation limits.
  localparam int                  WHEEL_W       = 18;
  localparam int                  WHEEL_POS_LIM = 131071;
  localparam int                  WHEEL_NEG_LIM = 131072;
  localparam logic [WHEEL_W-1:0]  WHEEL_MAX_BITS = 18'h1FFFF;
  localparam logic [WHEEL_W-1:0]  WHEEL_MIN_BITS = 18'h20000;

  localparam logic [THR_W-1:0]  THR_RESET  = 16'd160;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd2;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SQX  = 7'b0000010,
    ST_SQY  = 7'b0000100,
    ST_ROOT = 7'b0001000,
    ST_EVAL = 7'b0010000,
    ST_GAIN = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

endpackage

/* design/touch_to_mouse_pinch_mapper.sv */
// Touch-to-mouse mapper with two-finger pinch zoom, top level.
// Uses tmpm_pkg for codes, limits and the sequencer state type.
//
// Usage:
//   Input channel (in_valid / in_stall): one touch event or soft reset request per
//   transfer. The block raises in_stall while it works on an event.
//   Result channel (out_valid / out_stall): one mouse result per touch event with a
//   valid pointer id; soft resets and dropped pointer ids give no result.
//   Configuration: cfg_we writes pinch threshold (index 0) or wheel gain (index 1).
// Sequence:
//   Without both fingers down, an accepted event goes straight to the final state and
//   its result is loaded into the output register. With both fingers down, one shared
//   multiplier forms the two squares, a one-bit-per-cycle square root follows, then the
//   threshold compare, the gain multiply when the threshold is exceeded, and the result
//   load. The next event is taken in the cycle after the result is in the output
//   register, even while that result is still waiting.
// Reset: synchronous, active low; clears pointers, pinch reference, cursor, button and
//   restores the register defaults. No clearing pass is needed.
// Stall: a stalled result holds in the output register; a finished event waits in its
//   last state until the register frees up.
module touch_to_mouse_pinch_mapper #(
  parameter int COORD_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [tmpm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tmpm_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_req_type,
  input  logic [15:0]                           in_action,
  input  logic [tmpm_pkg::PID_W-1:0]            in_pointer_id,
  input  logic [COORD_BITS-1:0]                 in_touch_x,
  input  logic [COORD_BITS-1:0]                 in_touch_y,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [COORD_BITS-1:0]                 out_pos_x,
  output logic [COORD_BITS-1:0]                 out_pos_y,
  output logic signed [COORD_BITS:0]            out_move_dx,
  output logic signed [COORD_BITS:0]            out_move_dy,
  output logic [1:0]                            out_left_state,
  output logic signed [tmpm_pkg::WHEEL_W-1:0]   out_wheel_delta
);

  localparam int CB     = COORD_BITS;
  localparam int SQ_W   = 2 * CB + 1;
  localparam int DIST_W = CB + 5;
  localparam int RAD_W  = 2 * DIST_W;
  localparam int REM_W  = DIST_W + 2;
  localparam int CNT_W  = $clog2(DIST_W);
  localparam int PROD_W = DIST_W + CB;
  localparam int CMP_W  = (DIST_W > tmpm_pkg::THR_W) ? DIST_W : tmpm_pkg::THR_W;
  localparam int MAG_X  = ((DIST_W > tmpm_pkg::WHEEL_W) ? DIST_W : tmpm_pkg::WHEEL_W) + 1;
  localparam logic [tmpm_pkg::PID_W:0] PID_LIMIT = (tmpm_pkg::PID_W + 1)'(tmpm_pkg::MAX_POINTERS);

  tmpm_pkg::state_t state_r, state_nxt;

  logic              slot_act_r [2];
  logic              slot_act_nxt [2];
  logic [CB-1:0]     slot_x_r [2];
  logic [CB-1:0]     slot_x_nxt [2];
  logic [CB-1:0]     slot_y_r [2];
  logic [CB-1:0]     slot_y_nxt [2];

  logic [DIST_W-1:0] last_r, last_nxt;
  logic [CB-1:0]     cur_x_r, cur_x_nxt;
  logic [CB-1:0]     cur_y_r, cur_y_nxt;
  logic              btn_r, btn_nxt;
  logic [tmpm_pkg::THR_W-1:0]  thr_r, thr_nxt;
  logic [tmpm_pkg::GAIN_W-1:0] gain_r, gain_nxt;

  logic [CB-1:0]     res_px_r, res_px_nxt;
  logic [CB-1:0]     res_py_r, res_py_nxt;
  logic [CB:0]       res_dx_r, res_dx_nxt;
  logic [CB:0]       res_dy_r, res_dy_nxt;
  logic [1:0]        res_left_r, res_left_nxt;

  logic [SQ_W-1:0]   acc_r, acc_nxt;
  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DIST_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIST_W-1:0] ad_r, ad_nxt;
  logic              neg_r, neg_nxt;
  logic [DIST_W-1:0] mag_r, mag_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [CB-1:0]               out_px_r, out_px_nxt;
  logic [CB-1:0]               out_py_r, out_py_nxt;
  logic [CB:0]                 out_dx_r, out_dx_nxt;
  logic [CB:0]                 out_dy_r, out_dy_nxt;
  logic [1:0]                  out_left_r, out_left_nxt;
  logic [tmpm_pkg::WHEEL_W-1:0] out_wheel_r, out_wheel_nxt;

  // Shared multiplier: squares of the finger spacing, then the wheel gain.
  logic [DIST_W-1:0] mul_a;
  logic [CB-1:0]     mul_b;
  logic [PROD_W-1:0] prod;

  logic [CB:0]       sep_x, sep_y;
  logic [CB-1:0]     abs_x, abs_y;
  logic [SQ_W-1:0]   sq_sum;
  logic [REM_W-1:0]  rem_sh, trial;
  logic [DIST_W:0]   diff;
  logic [DIST_W-1:0] abs_diff;
  logic [MAG_X-1:0]  mag_ext;
  logic [tmpm_pkg::WHEEL_W-1:0] wheel_bits;
  logic [7:0]        act;
  logic              accept, out_free;

  assign act      = in_action[7:0];
  assign in_stall = (state_r != tmpm_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign sep_x = {1'b0, slot_x_r[0]} - {1'b0, slot_x_r[1]};
  assign sep_y = {1'b0, slot_y_r[0]} - {1'b0, slot_y_r[1]};
  assign abs_x = sep_x[CB] ? CB'(-sep_x) : sep_x[CB-1:0];
  assign abs_y = sep_y[CB] ? CB'(-sep_y) : sep_y[CB-1:0];

  always_comb begin
    mul_a = DIST_W'(abs_x);
    mul_b = abs_x;
    case (state_r)
      tmpm_pkg::ST_SQY: begin
        mul_a = DIST_W'(abs_y);
        mul_b = abs_y;
      end
      tmpm_pkg::ST_GAIN: begin
        mul_a = ad_r;
        mul_b = CB'(gain_r);
      end
      default: begin
        mul_a = DIST_W'(abs_x);
        mul_b = abs_x;
      end
    endcase
  end

  assign prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign sq_sum = acc_r + SQ_W'(prod);

  // One root bit per cycle: bring down two radicand bits and try root*4+1.
  assign rem_sh = {rem_r[DIST_W-1:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  assign diff     = {1'b0, root_r} - {1'b0, last_r};
  assign abs_diff = diff[DIST_W] ? DIST_W'(-diff) : diff[DIST_W-1:0];

  // Negate and saturate the wheel magnitude.
  always_comb begin
    mag_ext = MAG_X'(mag_r);
    if (!neg_r) begin
      if (mag_ext > MAG_X'(tmpm_pkg::WHEEL_POS_LIM)) begin
        wheel_bits = tmpm_pkg::WHEEL_MAX_BITS;
      end else begin
        wheel_bits = tmpm_pkg::WHEEL_W'(mag_ext);
      end
    end else begin
      if (mag_ext > MAG_X'(tmpm_pkg::WHEEL_NEG_LIM)) begin
        wheel_bits = tmpm_pkg::WHEEL_MIN_BITS;
      end else begin
        wheel_bits = tmpm_pkg::WHEEL_W'(-mag_ext);
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    for (int i = 0; i < 2; i++) begin
      slot_act_nxt[i] = slot_act_r[i];
      slot_x_nxt[i]   = slot_x_r[i];
      slot_y_nxt[i]   = slot_y_r[i];
    end
    last_nxt     = last_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    btn_nxt      = btn_r;
    thr_nxt      = thr_r;
    gain_nxt     = gain_r;
    res_px_nxt   = res_px_r;
    res_py_nxt   = res_py_r;
    res_dx_nxt   = res_dx_r;
    res_dy_nxt   = res_dy_r;
    res_left_nxt = res_left_r;
    acc_nxt      = acc_r;
    rad_nxt      = rad_r;
    rem_nxt      = rem_r;
    root_nxt     = root_r;
    cnt_nxt      = cnt_r;
    ad_nxt       = ad_r;
    neg_nxt      = neg_r;
    mag_nxt      = mag_r;
    out_px_nxt    = out_px_r;
    out_py_nxt    = out_py_r;
    out_dx_nxt    = out_dx_r;
    out_dy_nxt    = out_dy_r;
    out_left_nxt  = out_left_r;
    out_wheel_nxt = out_wheel_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cfg_we) begin
      case (cfg_index)
        tmpm_pkg::REG_THRESHOLD: thr_nxt  = cfg_data[tmpm_pkg::THR_W-1:0];
        tmpm_pkg::REG_GAIN:      gain_nxt = cfg_data[tmpm_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      tmpm_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_req_type) begin
            for (int i = 0; i < 2; i++) begin
              slot_act_nxt[i] = 1'b0;
            end
            last_nxt = '0;
            btn_nxt  = 1'b0;
          end else if ({1'b0, in_pointer_id} < PID_LIMIT) begin
            if (in_pointer_id[tmpm_pkg::PID_W-1:1] == '0) begin
              case (act)
                tmpm_pkg::ACT_DOWN, tmpm_pkg::ACT_PTR_DOWN: begin
                  slot_act_nxt[in_pointer_id[0]] = 1'b1;
                  slot_x_nxt[in_pointer_id[0]]   = in_touch_x;
                  slot_y_nxt[in_pointer_id[0]]   = in_touch_y;
                end
                tmpm_pkg::ACT_UP, tmpm_pkg::ACT_PTR_UP, tmpm_pkg::ACT_CANCEL: begin
                  slot_act_nxt[in_pointer_id[0]] = 1'b0;
                end
                tmpm_pkg::ACT_MOVE: begin
                  slot_x_nxt[in_pointer_id[0]] = in_touch_x;
                  slot_y_nxt[in_pointer_id[0]] = in_touch_y;
                end
                default: ;
              endcase
            end

            if (in_pointer_id == '0) begin
              res_px_nxt = in_touch_x;
              res_py_nxt = in_touch_y;
              res_dx_nxt = {1'b0, in_touch_x} - {1'b0, cur_x_r};
              res_dy_nxt = {1'b0, in_touch_y} - {1'b0, cur_y_r};
              cur_x_nxt  = in_touch_x;
              cur_y_nxt  = in_touch_y;
              case (act)
                tmpm_pkg::ACT_DOWN: begin
                  res_left_nxt = tmpm_pkg::LEFT_DOWN;
                  btn_nxt      = 1'b1;
                end
                tmpm_pkg::ACT_UP: begin
                  res_left_nxt = tmpm_pkg::LEFT_UP;
                  btn_nxt      = 1'b0;
                end
                tmpm_pkg::ACT_MOVE: begin
                  res_left_nxt = btn_r ? tmpm_pkg::LEFT_DOWN : tmpm_pkg::LEFT_UP;
                end
                default: begin
                  res_left_nxt = tmpm_pkg::LEFT_NONE;
                end
              endcase
            end else begin
              res_px_nxt   = cur_x_r;
              res_py_nxt   = cur_y_r;
              res_dx_nxt   = '0;
              res_dy_nxt   = '0;
              res_left_nxt = btn_r ? tmpm_pkg::LEFT_DOWN : tmpm_pkg::LEFT_UP;
            end

            neg_nxt = 1'b0;
            mag_nxt = '0;
            if (slot_act_nxt[0] && slot_act_nxt[1]) begin
              state_nxt = tmpm_pkg::ST_SQX;
            end else begin
              last_nxt  = '0;
              state_nxt = tmpm_pkg::ST_DONE;
            end
          end
        end
      end

      tmpm_pkg::ST_SQX: begin
        acc_nxt   = SQ_W'(prod);
        state_nxt = tmpm_pkg::ST_SQY;
      end

      tmpm_pkg::ST_SQY: begin
        // Radicand is the squared spacing times 256, so the root comes out in Q.4.
        rad_nxt   = RAD_W'(sq_sum) << 8;
        rem_nxt   = '0;
        root_nxt  = '0;
        cnt_nxt   = CNT_W'(DIST_W - 1);
        state_nxt = tmpm_pkg::ST_ROOT;
      end

      tmpm_pkg::ST_ROOT: begin
        rad_nxt = rad_r << 2;
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[DIST_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[DIST_W-2:0], 1'b0};
        end
        if (cnt_r == '0) begin
          state_nxt = tmpm_pkg::ST_EVAL;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end

      tmpm_pkg::ST_EVAL: begin
        // A zero reference means none is held yet: take this distance as the reference.
        if (last_r == '0) begin
          last_nxt  = root_r;
          state_nxt = tmpm_pkg::ST_DONE;
        end else if (CMP_W'(abs_diff) > CMP_W'(thr_r)) begin
          last_nxt  = root_r;
          ad_nxt    = abs_diff;
          neg_nxt   = diff[DIST_W];
          state_nxt = tmpm_pkg::ST_GAIN;
        end else begin
          state_nxt = tmpm_pkg::ST_DONE;
        end
      end

      tmpm_pkg::ST_GAIN: begin
        mag_nxt   = DIST_W'(prod >> 4);
        state_nxt = tmpm_pkg::ST_DONE;
      end

      tmpm_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_px_nxt    = res_px_r;
          out_py_nxt    = res_py_r;
          out_dx_nxt    = res_dx_r;
          out_dy_nxt    = res_dy_r;
          out_left_nxt  = res_left_r;
          out_wheel_nxt = wheel_bits;
          state_nxt     = tmpm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tmpm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tmpm_pkg::ST_IDLE;
      slot_act_r[0] <= 1'b0;
      slot_act_r[1] <= 1'b0;
      last_r      <= '0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      btn_r       <= 1'b0;
      thr_r       <= tmpm_pkg::THR_RESET;
      gain_r      <= tmpm_pkg::GAIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_act_r[0] <= slot_act_nxt[0];
      slot_act_r[1] <= slot_act_nxt[1];
      last_r      <= last_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      btn_r       <= btn_nxt;
      thr_r       <= thr_nxt;
      gain_r      <= gain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      slot_x_r[i] <= slot_x_nxt[i];
      slot_y_r[i] <= slot_y_nxt[i];
    end
    res_px_r    <= res_px_nxt;
    res_py_r    <= res_py_nxt;
    res_dx_r    <= res_dx_nxt;
    res_dy_r    <= res_dy_nxt;
    res_left_r  <= res_left_nxt;
    acc_r       <= acc_nxt;
    rad_r       <= rad_nxt;
    rem_r       <= rem_nxt;
    root_r      <= root_nxt;
    cnt_r       <= cnt_nxt;
    ad_r        <= ad_nxt;
    neg_r       <= neg_nxt;
    mag_r       <= mag_nxt;
    out_px_r    <= out_px_nxt;
    out_py_r    <= out_py_nxt;
    out_dx_r    <= out_dx_nxt;
    out_dy_r    <= out_dy_nxt;
    out_left_r  <= out_left_nxt;
    out_wheel_r <= out_wheel_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pos_x       = out_px_r;
  assign out_pos_y       = out_py_r;
  assign out_move_dx     = $signed(out_dx_r);
  assign out_move_dy     = $signed(out_dy_r);
  assign out_left_state  = out_left_r;
  assign out_wheel_delta = $signed(out_wheel_r);

  // The square root only runs while both fingers are down.
  a_root_needs_two_fingers: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tmpm_pkg::ST_ROOT |-> slot_act_r[0] && slot_act_r[1])
    else $error("pinch root running without two active pointers");

  // A dropped pointer id starts no work.
  a_dropped_id_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_req_type && ({1'b0, in_pointer_id} >= PID_LIMIT)
    |=> state_r == tmpm_pkg::ST_IDLE)
    else $error("dropped pointer id started processing");

  // A soft reset leaves no finger down and no pinch reference.
  a_soft_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_req_type |=> !slot_act_r[0] && !slot_act_r[1] && last_r == '0)
    else $error("soft reset left touch state behind");

  // A new result only enters the output register from the final state.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == tmpm_pkg::ST_DONE)
    else $error("result loaded outside the final state");

endmodule

/* bench/tmpm_report_checker.sv */
// Checker for the touch-to-mouse pinch mapper: watches the register port and both channels,
// predicts each mouse report and compares it field by field with what the block sends.
// Depends on tmpm_pkg for the action, button and register codes.
`timescale 1ns / 1ps

module tmpm_report_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tmpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tmpm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_req_type,
  input  logic [15:0]                         in_action,
  input  logic [tmpm_pkg::PID_W-1:0]          in_pointer_id,
  input  logic [11:0]                         in_touch_x,
  input  logic [11:0]                         in_touch_y,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [11:0]                         out_pos_x,
  input  logic [11:0]                         out_pos_y,
  input  logic [12:0]                         out_move_dx,
  input  logic [12:0]                         out_move_dy,
  input  logic [1:0]                          out_left_state,
  input  logic [tmpm_pkg::WHEEL_W-1:0]        out_wheel_delta,
  output int                                  mismatches,
  output int                                  reports_waiting
);

  typedef struct packed {
    logic [11:0]                  pos_x;
    logic [11:0]                  pos_y;
    logic [12:0]                  move_dx;
    logic [12:0]                  move_dy;
    logic [1:0]                   left;
    logic [tmpm_pkg::WHEEL_W-1:0] wheel;
  } mouse_report_t;

  mouse_report_t   expected_reports[$];
  int              error_total = 0;

  // Shadow of the block's state and registers.
  logic            finger_on[2];
  logic [11:0]     finger_x[2];
  logic [11:0]     finger_y[2];
  longint unsigned pinch_ref;
  logic [11:0]     cursor_x;
  logic [11:0]     cursor_y;
  logic            button_held;
  logic [tmpm_pkg::THR_W-1:0]  pinch_thr;
  logic [tmpm_pkg::GAIN_W-1:0] wheel_gain;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    error_total++;
  endtask

  task automatic compare_field(input string name, input longint unsigned want,
                               input longint unsigned got);
    if (want !== got)
      report_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
  endtask

  task automatic enqueue_report(input mouse_report_t rep);
    expected_reports = {expected_reports, rep};
  endtask

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 17; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  task automatic clear_touch();
    for (int i = 0; i < 2; i++) begin
      finger_on[i] = 1'b0;
      finger_x[i]  = '0;
      finger_y[i]  = '0;
    end
    pinch_ref   = 0;
    button_held = 1'b0;
  endtask

  // Applies one accepted event to the shadow state and forms the report it causes.
  task automatic apply_touch_event(input logic req, input logic [15:0] action_raw,
                                   input logic [tmpm_pkg::PID_W-1:0] pid,
                                   input logic [11:0] x, input logic [11:0] y,
                                   output bit produced, output mouse_report_t rep);
    logic [7:0]      act;
    longint          dx;
    longint          dy;
    longint          d;
    longint          ad;
    longint          mag;
    longint          wheel;
    longint unsigned pinch_dist;
    produced = 1'b0;
    rep      = '0;
    act      = action_raw[7:0];
    wheel    = 0;
    if (req) begin
      clear_touch();
      return;
    end
    if (pid >= tmpm_pkg::MAX_POINTERS) return;

    if (pid < 2) begin
      case (act)
        tmpm_pkg::ACT_DOWN, tmpm_pkg::ACT_PTR_DOWN: begin
          finger_on[pid[0]] = 1'b1;
          finger_x[pid[0]]  = x;
          finger_y[pid[0]]  = y;
        end
        tmpm_pkg::ACT_UP, tmpm_pkg::ACT_PTR_UP, tmpm_pkg::ACT_CANCEL:
          finger_on[pid[0]] = 1'b0;
        tmpm_pkg::ACT_MOVE: begin
          finger_x[pid[0]] = x;
          finger_y[pid[0]] = y;
        end
        default: ;
      endcase
    end

    if (finger_on[0] && finger_on[1]) begin
      dx         = longint'(finger_x[0]) - longint'(finger_x[1]);
      dy         = longint'(finger_y[0]) - longint'(finger_y[1]);
      pinch_dist = floor_sqrt(longint'(dx * dx + dy * dy) * 256);
      // A reference of zero means none is held, so the distance is simply taken.
      if (pinch_ref != 0) begin
        d  = longint'(pinch_dist) - longint'(pinch_ref);
        ad = (d < 0) ? -d : d;
        if (ad > longint'(pinch_thr)) begin
          mag   = (ad * longint'(wheel_gain)) / 16;
          wheel = (d < 0) ? -mag : mag;
          if (wheel > tmpm_pkg::WHEEL_POS_LIM) wheel = tmpm_pkg::WHEEL_POS_LIM;
          if (wheel < -tmpm_pkg::WHEEL_NEG_LIM) wheel = -tmpm_pkg::WHEEL_NEG_LIM;
          pinch_ref = pinch_dist;
        end
      end else begin
        pinch_ref = pinch_dist;
      end
    end else begin
      pinch_ref = 0;
    end

    if (pid == 0) begin
      rep.pos_x   = x;
      rep.pos_y   = y;
      rep.move_dx = 13'(longint'(x) - longint'(cursor_x));
      rep.move_dy = 13'(longint'(y) - longint'(cursor_y));
      cursor_x    = x;
      cursor_y    = y;
      case (act)
        tmpm_pkg::ACT_DOWN: begin
          rep.left    = tmpm_pkg::LEFT_DOWN;
          button_held = 1'b1;
        end
        tmpm_pkg::ACT_UP: begin
          rep.left    = tmpm_pkg::LEFT_UP;
          button_held = 1'b0;
        end
        tmpm_pkg::ACT_MOVE: rep.left = button_held ? tmpm_pkg::LEFT_DOWN : tmpm_pkg::LEFT_UP;
        default:            rep.left = tmpm_pkg::LEFT_NONE;
      endcase
    end else begin
      rep.pos_x = cursor_x;
      rep.pos_y = cursor_y;
      rep.left  = button_held ? tmpm_pkg::LEFT_DOWN : tmpm_pkg::LEFT_UP;
    end
    rep.wheel = tmpm_pkg::WHEEL_W'(wheel);
    produced  = 1'b1;
  endtask

  always @(posedge clk) begin : watch
    mouse_report_t want;
    mouse_report_t fresh;
    bit            produced;
    if (!rst_n) begin
      clear_touch();
      cursor_x   = '0;
      cursor_y   = '0;
      pinch_thr  = tmpm_pkg::THR_RESET;
      wheel_gain = tmpm_pkg::GAIN_RESET;
      expected_reports.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("result transfer with no event waiting for it");
        end else begin
          want = expected_reports.pop_front();
          compare_field("pos_x", want.pos_x, out_pos_x);
          compare_field("pos_y", want.pos_y, out_pos_y);
          compare_field("move_dx", want.move_dx, out_move_dx);
          compare_field("move_dy", want.move_dy, out_move_dy);
          compare_field("left_state", want.left, out_left_state);
          compare_field("wheel_delta", want.wheel, out_wheel_delta);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          tmpm_pkg::REG_THRESHOLD: pinch_thr  = cfg_data[tmpm_pkg::THR_W-1:0];
          tmpm_pkg::REG_GAIN:      wheel_gain = cfg_data[tmpm_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        apply_touch_event(in_req_type, in_action, in_pointer_id, in_touch_x, in_touch_y,
                          produced, fresh);
        if (produced) enqueue_report(fresh);
      end
    end
    mismatches      <= error_total;
    reports_waiting <= expected_reports.size();
  end

endmodule

/* bench/tb_touch_to_mouse_pinch_mapper.sv */
// Testbench top for the touch-to-mouse pinch mapper: clock, reset, register writes,
// directed and random touch traffic with bursty input and a stalling receiver.
// Depends on tmpm_pkg, the block and tmpm_report_checker.
`timescale 1ns / 1ps

module tb_touch_to_mouse_pinch_mapper;

  localparam logic [7:0] ACT_UNKNOWN    = 8'd4;
  localparam logic [7:0] ACT_UNKNOWN_FF = 8'hFF;
  localparam int         PHASE_EVENTS   = 96;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               cfg_we = 1'b0;
  logic [tmpm_pkg::CFG_IDX_W-1:0]     cfg_index = tmpm_pkg::REG_THRESHOLD;
  logic [tmpm_pkg::CFG_DATA_W-1:0]    cfg_data = '0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic                               in_req_type = 1'b0;
  logic [15:0]                        in_action = '0;
  logic [tmpm_pkg::PID_W-1:0]         in_pointer_id = '0;
  logic [11:0]                        in_touch_x = '0;
  logic [11:0]                        in_touch_y = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [11:0]                        out_pos_x;
  logic [11:0]                        out_pos_y;
  logic signed [12:0]                 out_move_dx;
  logic signed [12:0]                 out_move_dy;
  logic [1:0]                         out_left_state;
  logic signed [tmpm_pkg::WHEEL_W-1:0] out_wheel_delta;
  int                                 mismatches;
  int                                 reports_waiting;

  int events_sent = 0;
  int burst_left  = 0;

  always #5 clk = ~clk;

  touch_to_mouse_pinch_mapper dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_action       (in_action),
    .in_pointer_id   (in_pointer_id),
    .in_touch_x      (in_touch_x),
    .in_touch_y      (in_touch_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_move_dx     (out_move_dx),
    .out_move_dy     (out_move_dy),
    .out_left_state  (out_left_state),
    .out_wheel_delta (out_wheel_delta)
  );

  tmpm_report_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_action       (in_action),
    .in_pointer_id   (in_pointer_id),
    .in_touch_x      (in_touch_x),
    .in_touch_y      (in_touch_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_move_dx     (out_move_dx),
    .out_move_dy     (out_move_dy),
    .out_left_state  (out_left_state),
    .out_wheel_delta (out_wheel_delta),
    .mismatches      (mismatches),
    .reports_waiting (reports_waiting)
  );

  function automatic logic [7:0] action_high();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h00;
  endfunction

  // Mostly small finger drift, now and then a large jump, kept on the screen.
  function automatic logic [11:0] nudge(input logic [11:0] c);
    int v;
    if ($urandom_range(0, 9) == 0) v = int'(c) + int'($urandom_range(0, 8190)) - 4095;
    else v = int'(c) + int'($urandom_range(0, 80)) - 40;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  // Ends a burst with a random gap, or counts down the current burst.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_item(input logic rq, input logic [15:0] act,
                           input logic [tmpm_pkg::PID_W-1:0] pid,
                           input logic [11:0] x, input logic [11:0] y);
    in_valid      <= 1'b1;
    in_req_type   <= rq;
    in_action     <= act;
    in_pointer_id <= pid;
    in_touch_x    <= x;
    in_touch_y    <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!rq && pid < tmpm_pkg::MAX_POINTERS) events_sent++;
    pace();
  endtask

  task automatic noise_item();
    logic [15:0] act;
    if ($urandom_range(0, 1) == 1) act = 16'($urandom());
    else act = {action_high(), 8'($urandom_range(0, 7))};
    send_item(($urandom_range(0, 11) == 0), act, tmpm_pkg::PID_W'($urandom_range(0, 15)),
              12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
  endtask

  // One finger down, often a second one, some moves, then the fingers lift.
  task automatic play_gesture();
    logic [11:0] ax;
    logic [11:0] ay;
    logic [11:0] bx;
    logic [11:0] by;
    bit          two;
    int          moves;
    ax    = 12'($urandom_range(0, 4095));
    ay    = 12'($urandom_range(0, 4095));
    bx    = 12'($urandom_range(0, 4095));
    by    = 12'($urandom_range(0, 4095));
    two   = ($urandom_range(0, 3) != 0);
    moves = $urandom_range(1, 12);
    send_item(1'b0, {action_high(), tmpm_pkg::ACT_DOWN}, 4'd0, ax, ay);
    if (two) send_item(1'b0, {action_high(), tmpm_pkg::ACT_PTR_DOWN}, 4'd1, bx, by);
    repeat (moves) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          ax = nudge(ax);
          ay = nudge(ay);
          send_item(1'b0, {action_high(), tmpm_pkg::ACT_MOVE}, 4'd0, ax, ay);
        end
        4, 5, 6, 7: begin
          bx = nudge(bx);
          by = nudge(by);
          send_item(1'b0, {action_high(), tmpm_pkg::ACT_MOVE}, 4'd1, bx, by);
        end
        8: send_item(1'b0, {action_high(), tmpm_pkg::ACT_MOVE},
                     tmpm_pkg::PID_W'($urandom_range(2, 15)),
                     12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        default: noise_item();
      endcase
    end
    if (two)
      send_item(1'b0, {action_high(), ($urandom_range(0, 3) == 0) ? tmpm_pkg::ACT_CANCEL
                                                                  : tmpm_pkg::ACT_PTR_UP},
                4'd1, bx, by);
    send_item(1'b0, {action_high(), ($urandom_range(0, 5) == 0) ? tmpm_pkg::ACT_CANCEL
                                                                : tmpm_pkg::ACT_UP},
              4'd0, ax, ay);
  endtask

  // Waits until every report has come out, then lets the block finish any event that
  // gives no report.
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_waiting != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic configure(input logic [tmpm_pkg::THR_W-1:0] thr,
                           input logic [tmpm_pkg::GAIN_W-1:0] gain);
    cfg_we    <= 1'b1;
    cfg_index <= tmpm_pkg::REG_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_index <= tmpm_pkg::REG_GAIN;
    cfg_data  <= {12'($urandom_range(0, 4095)), gain};
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int target;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    configure(tmpm_pkg::THR_RESET, tmpm_pkg::GAIN_RESET);

    send_item(1'b0, {8'h00, tmpm_pkg::ACT_DOWN}, 4'd0, 12'd0, 12'd0);
    send_item(1'b0, {8'h00, tmpm_pkg::ACT_MOVE}, 4'd0, 12'd4095, 12'd4095);
    send_item(1'b0, {8'h00, tmpm_pkg::ACT_PTR_DOWN}, 4'd1, 12'd0, 12'd0);
    send_item(1'b0, {8'hFF, tmpm_pkg::ACT_MOVE}, 4'd1, 12'd4095, 12'd0);
    // Fingers on the same spot: the reference drops to zero and is taken afresh next time.
    send_item(1'b0, {8'h00, tmpm_pkg::ACT_MOVE}, 4'd1, 12'd4095, 12'd4095);
    send_item(1'b0, {8'h00, tmpm_pkg::ACT_MOVE}, 4'd1, 12'd0, 12'd4095);
    send_item(1'b0, {8'h00, tmpm_pkg::ACT_MOVE}, 4'd0, 12'd2048, 12'd4095);
    send_item(1'b0, {8'h00, tmpm_pkg::ACT_MOVE}, 4'd0, 12'd2060, 12'd4095);
    send_item(1'b0, {8'h00, tmpm_pkg::ACT_MOVE}, 4'd0, 12'd2065, 12'd4095);
    send_item(1'b0, {8'h00, tmpm_pkg::ACT_MOVE}, 4'd2, 12'd100, 12'd100);
    send_item(1'b0, {8'h00, tmpm_pkg::ACT_DOWN}, tmpm_pkg::PID_W'(tmpm_pkg::MAX_POINTERS - 1),
              12'd7, 12'd7);
    send_item(1'b0, {8'h00, tmpm_pkg::ACT_DOWN}, tmpm_pkg::PID_W'(tmpm_pkg::MAX_POINTERS),
              12'd9, 12'd9);
    send_item(1'b0, {8'h00, tmpm_pkg::ACT_MOVE}, 4'hF, 12'd4095, 12'd4095);
    send_item(1'b0, {8'h00, ACT_UNKNOWN}, 4'd0, 12'd5, 12'd6);
    send_item(1'b0, {8'h00, ACT_UNKNOWN_FF}, 4'd0, 12'd50, 12'd60);
    send_item(1'b0, {8'h00, tmpm_pkg::ACT_CANCEL}, 4'd0, 12'd70, 12'd80);
    send_item(1'b0, {8'h00, tmpm_pkg::ACT_PTR_DOWN}, 4'd0, 12'd300, 12'd300);
    send_item(1'b0, {8'h00, tmpm_pkg::ACT_PTR_UP}, 4'd0, 12'd310, 12'd290);
    send_item(1'b0, {8'h00, tmpm_pkg::ACT_CANCEL}, 4'd1, 12'd1, 12'd1);
    send_item(1'b0, {8'h00, tmpm_pkg::ACT_PTR_UP}, 4'd1, 12'd2, 12'd2);
    send_item(1'b1, 16'hFFFF, 4'hF, 12'd4095, 12'd4095);
    send_item(1'b0, {8'h00, tmpm_pkg::ACT_MOVE}, 4'd0, 12'd7, 12'd9);
    send_item(1'b0, {8'h00, tmpm_pkg::ACT_DOWN}, 4'd0, 12'd4095, 12'd0);
    send_item(1'b0, {8'h00, tmpm_pkg::ACT_UP}, 4'd0, 12'd0, 12'd4095);
    send_item(1'b0, {8'h00, tmpm_pkg::ACT_UP}, 4'd1, 12'd0, 12'd0);

    for (int phase = 0; phase < 7; phase++) begin
      drain_block();
      case (phase)
        0: configure(16'd0, 4'd15);
        1: configure(16'hFFFF, 4'd0);
        2: configure(16'd16, 4'd1);
        3: configure(tmpm_pkg::THR_W'($urandom_range(0, 400)),
                     tmpm_pkg::GAIN_W'($urandom_range(0, 15)));
        4: configure(16'd0, 4'd0);
        5: configure(16'hFFFF, 4'd15);
        default: configure(tmpm_pkg::THR_W'($urandom_range(0, 65535)),
                           tmpm_pkg::GAIN_W'($urandom_range(0, 15)));
      endcase
      target = events_sent + PHASE_EVENTS;
      while (events_sent < target) begin
        if ($urandom_range(0, 9) < 8) play_gesture();
        else noise_item();
      end
    end

    drain_block();
    if (mismatches == 0 && reports_waiting == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver: stall patterns in segments, with a long hold-off now and then so the
  // result register stays full and the block has to stall its input.
  initial begin : receiver
    int segment;
    int span;
    int mode;
    int tick;
    segment = 0;
    tick    = 0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      segment++;
      if (segment % 60 == 20) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(10, 80);
        repeat (span) begin
          tick++;
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 99) < 30);
            2:       out_stall <= ($urandom_range(0, 99) < 75);
            default: out_stall <= (tick % 3 == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
